/* rtl/fpba_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types and codes for the fit policy block allocator: the request and
// response words, the control register indexes and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package fpba_pkg;

   // Operation codes carried in the request word.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_ALLOC = 1'b1;

   // Placement policies. The unused code behaves as first fit.
   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_WORST = 2'd1;
   localparam logic [1:0] FIT_BEST  = 2'd2;

   // Control register indexes.
   localparam logic [1:0] CSR_FIT_MODE      = 2'd0;
   localparam logic [1:0] CSR_BLOCKS_IN_USE = 2'd1;

   // Reset values of the control registers.
   localparam logic [1:0] FIT_MODE_RESET      = FIT_FIRST;
   localparam logic [4:0] BLOCKS_IN_USE_RESET = 5'd16;

   typedef logic [1:0] csr_index_type;
   typedef logic [7:0] csr_data_type;

   typedef struct packed {
      logic        opcode;
      logic [3:0]  entry_index;
      logic [15:0] size_value;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [3:0]  chosen_index;
      logic [15:0] block_size_before;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;   // latch the request word and restart the search
      logic scan;     // issue the next table read of the search
      logic finish;   // write back the table and load the response word
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_is_load;  // the offered request word is a load
      logic scan_done;    // every searched entry has been read
      logic rsp_busy;     // the response register is full and stalled
   } dp_status_type;

endpackage

/* rtl/fpba_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_ctrl
// Sequencer of the allocator: takes a request word, runs the table search
// for an allocation and hands the result to the response register.
// ----------------------------------------------------------------------------
module fpba_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  fpba_pkg::dp_status_type status,
   output fpba_pkg::dp_cmd_type    cmd
);
   import fpba_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = status.req_is_load ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            // The last read is compared in the cycle that sees scan_done.
            if (status.scan_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         ST_FINISH: begin
            if (!status.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_one_word_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("a second request word was taken while one was in progress");

   a_finish_not_stalled: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !status.rsp_busy)
      else $error("response overwritten while the receiver stalled");

endmodule

/* rtl/fpba_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_dpath
// Datapath of the allocator: control registers, the free size table with its
// valid bits, the search counter, the running pick and the response register.
// ----------------------------------------------------------------------------
module fpba_dpath #(
   parameter int TABLE_DEPTH = 16,
   parameter int SIZE_BITS   = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fpba_pkg::req_type       req_data,
   input  fpba_pkg::dp_cmd_type    cmd,
   output fpba_pkg::dp_status_type status,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output fpba_pkg::rsp_type       rsp_data,
   input  logic                    csr_valid,
   input  fpba_pkg::csr_index_type csr_index,
   input  fpba_pkg::csr_data_type  csr_wdata
);
   import fpba_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

   // Control registers.
   logic [1:0] fit_mode_ff;
   logic [4:0] blocks_in_use_ff;

   // Latched request.
   logic                 op_ff;
   logic [3:0]           idx_ff;
   logic [SIZE_BITS-1:0] size_ff;

   // Table and its read stage.
   logic [SIZE_BITS-1:0] mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [SIZE_BITS-1:0] rd_data_ff;
   logic                 rd_vld_ff;
   logic [CNT_W-1:0]     rd_cnt_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic                 cmp_vld_ff;
   logic [IDX_W-1:0]     cmp_idx_ff;

   // Running pick.
   logic                 have_ff;
   logic [IDX_W-1:0]     pick_idx_ff;
   logic [SIZE_BITS-1:0] pick_size_ff;

   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   logic [CMP_W-1:0]     depth_ext;
   logic [CMP_W-1:0]     bu_ext;
   logic [CMP_W-1:0]     count_lim;
   logic                 issue_ok;
   logic                 scan_issue;
   logic [SIZE_BITS-1:0] entry_size;
   logic                 fits;
   logic                 take;
   logic                 load_ok;
   rsp_type              result;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [SIZE_BITS-1:0] wr_data;

   // Search length: the register value, saturated to the table depth.
   assign depth_ext  = CMP_W'(TABLE_DEPTH);
   assign bu_ext     = CMP_W'(blocks_in_use_ff);
   assign count_lim  = (bu_ext > depth_ext) ? depth_ext : bu_ext;
   assign issue_ok   = CMP_W'(rd_cnt_ff) < count_lim;
   assign scan_issue = cmd.scan && issue_ok;
   assign rd_addr    = rd_cnt_ff[IDX_W-1:0];

   // An entry never written since reset reads as an empty block.
   assign entry_size = rd_vld_ff ? rd_data_ff : '0;
   assign fits       = entry_size >= size_ff;

   always_comb begin
      take = 1'b0;
      if (cmp_vld_ff && fits) begin
         if (!have_ff) begin
            take = 1'b1;
         end else if (fit_mode_ff == FIT_WORST) begin
            take = entry_size > pick_size_ff;
         end else if (fit_mode_ff == FIT_BEST) begin
            take = entry_size < pick_size_ff;
         end
      end
   end

   assign load_ok = CMP_W'(idx_ff) < depth_ext;

   always_comb begin
      result  = '0;
      wr_en   = 1'b0;
      wr_addr = pick_idx_ff;
      wr_data = pick_size_ff - size_ff;
      if (op_ff == OP_LOAD) begin
         wr_addr = IDX_W'(idx_ff);
         wr_data = size_ff;
         if (load_ok) begin
            wr_en                    = cmd.finish;
            result.found             = 1'b1;
            result.chosen_index      = idx_ff;
            result.block_size_before = 16'(size_ff);
         end
      end else if (have_ff) begin
         wr_en                    = cmd.finish;
         result.found             = 1'b1;
         result.chosen_index      = 4'(pick_idx_ff);
         result.block_size_before = 16'(pick_size_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff      <= FIT_MODE_RESET;
         blocks_in_use_ff <= BLOCKS_IN_USE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FIT_MODE:      fit_mode_ff      <= csr_wdata[1:0];
            CSR_BLOCKS_IN_USE: blocks_in_use_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // Request payload.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= req_data.opcode;
         idx_ff  <= req_data.entry_index;
         size_ff <= SIZE_BITS'(req_data.size_value);
      end
   end

   // Table: one write port used at finish, one read port used by the search.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (scan_issue) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_issue) begin
         rd_vld_ff  <= valid_ff[rd_addr];
         cmp_idx_ff <= rd_addr;
      end
      if (take) begin
         pick_idx_ff  <= cmp_idx_ff;
         pick_size_ff <= entry_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_cnt_ff  <= '0;
         cmp_vld_ff <= 1'b0;
         have_ff    <= 1'b0;
      end else begin
         cmp_vld_ff <= scan_issue;
         if (cmd.accept) begin
            rd_cnt_ff <= '0;
            have_ff   <= 1'b0;
         end else begin
            if (scan_issue) begin
               rd_cnt_ff <= rd_cnt_ff + 1'b1;
            end
            if (take) begin
               have_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign status.req_is_load = (req_data.opcode == OP_LOAD);
   assign status.scan_done   = !issue_ok;
   assign status.rsp_busy    = rsp_valid_ff && !rsp_ready;

   a_no_read_during_write: assert property (@(posedge clock) disable iff (reset)
      !(scan_issue && wr_en))
      else $error("table read and write back collided");

   a_finish_loads_word: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished result did not reach the response register");

   a_pick_fits: assert property (@(posedge clock) disable iff (reset)
      (have_ff && !cmd.accept) |=> (!have_ff || pick_size_ff >= size_ff))
      else $error("picked block is smaller than the request");

endmodule

/* rtl/fit_policy_block_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// Free block table with first, worst and best fit placement.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : request word. A load writes one table entry and echoes it; an
//            allocate searches the first blocks_in_use entries and shrinks
//            the chosen one by the request.
//   rsp_*  : one response word per request, held in an output register.
//   csr_*  : control register writes, always ready; write only while idle.
//            Index 0 is the fit mode, index 1 the number of searched entries.
// Timing:
//   A load goes from acceptance to the finish step, which writes the entry
//   and loads the response into the output register once it is not stalled.
//   An allocate reads one table entry per cycle through the single read port,
//   compares each read against the running pick, then finishes like a load.
// Reset clears the table to empty blocks (valid bits), the fit mode to first
// fit and the search length to 16. No clearing pass is needed.
// A stalled receiver holds the response; the next request is still taken and
// processed, and its result waits until the held word has been taken.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator #(
   parameter int TABLE_DEPTH = 16,
   parameter int SIZE_BITS   = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  fpba_pkg::req_type       req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output fpba_pkg::rsp_type       rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  fpba_pkg::csr_index_type csr_index,
   input  fpba_pkg::csr_data_type  csr_wdata
);
   import fpba_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   fpba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fpba_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .SIZE_BITS   (SIZE_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule
